// ===== rtl/core/two_level_interrupt_arbiter_defines.svh =====
// assertion macros used by the arbiter rtl
`ifndef TWO_LEVEL_INTERRUPT_ARBITER_DEFINES_SVH
`define TWO_LEVEL_INTERRUPT_ARBITER_DEFINES_SVH

`ifndef ASSERT_OFF
// checked property, ignored while reset is low
`define TLIA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked property, also during reset
`define TLIA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TLIA_ASSERT(lbl, clk, rst_n, prop, msg)
`define TLIA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/core/tlia_pkg.sv =====
package tlia_pkg;

    // number of interrupt vectors
    localparam int VEC_CNT = 32;
    // index width over the vectors
    localparam int IDX_W = (VEC_CNT > 1) ? $clog2(VEC_CNT) : 1;
    // width of the vector fields on the ports
    localparam int VEC_W = 5;
    // configuration port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 5;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_VEC = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_START = 2'd1;
    // entries of the rotate start table
    localparam int ROT_ENTRIES = 2 ** VEC_W;

    typedef enum logic [1:0] {
        CMD_RAISE = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_ACK   = 2'd2,
        CMD_RET   = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd             cmd;
        logic [VEC_W-1:0] vector;
    } t_in;

    typedef struct packed {
        logic [VEC_W-1:0] next_vector;
        logic             next_valid;
        logic             normal_active;
        logic             high_active;
    } t_out;

    typedef struct packed {
        logic high;
        logic norm;
    } t_flags;

    typedef struct packed {
        logic [VEC_W-1:0] vec;
        logic             valid;
    } t_pick;

    typedef logic [IDX_W-1:0] t_start_tbl [ROT_ENTRIES];

    // first vector of the rotating search for each rotate_start value
    function automatic t_start_tbl build_start_tbl();
        t_start_tbl tbl;
        for (int r = 0; r < ROT_ENTRIES; r++) begin
            tbl[r] = (r == 0) ? '0 : IDX_W'((r + 1) % VEC_CNT);
        end
        return tbl;
    endfunction

    localparam t_start_tbl START_TBL = build_start_tbl();

endpackage

// ===== rtl/core/tlia_pick.sv =====
module tlia_pick
    import tlia_pkg::*;
(
    input  logic [VEC_CNT-1:0] i_pending,
    input  t_flags             i_flags,
    input  logic [VEC_W-1:0]   i_high_vec,
    input  logic [VEC_W-1:0]   i_rot_start,
    output t_pick              o_pick
);

    logic [VEC_CNT-1:0] hv_onehot;
    logic               hv_hit;
    logic [IDX_W-1:0]   start;
    logic [VEC_CNT-1:0] upper_mask;
    logic [VEC_CNT-1:0] upper;
    logic [VEC_CNT-1:0] cand;
    logic [VEC_CNT-1:0] lsb;
    logic [IDX_W-1:0]   idx;

    // high vector pending check
    assign hv_onehot = VEC_CNT'(1) << i_high_vec;
    assign hv_hit = (i_high_vec != '0) && (|(i_pending & hv_onehot));

    // rotating search: vectors at or above the start point first, then wrap
    assign start = START_TBL[i_rot_start];
    assign upper_mask = ~((VEC_CNT'(1) << start) - VEC_CNT'(1));
    assign upper = i_pending & upper_mask;
    assign cand = (|upper) ? upper : i_pending;
    assign lsb = cand & (~cand + VEC_CNT'(1));

    // encode the isolated one-hot bit
    always_comb begin
        idx = '0;
        for (int i = 0; i < VEC_CNT; i++) begin
            if (lsb[i]) begin
                idx = idx | IDX_W'(i);
            end
        end
    end

    // level blocking and final choice
    always_comb begin
        o_pick = '0;
        if (i_flags.high) begin
            o_pick = '0;
        end else if (hv_hit) begin
            o_pick.vec = i_high_vec;
            o_pick.valid = 1'b1;
        end else if (i_flags.norm) begin
            o_pick = '0;
        end else if (|i_pending) begin
            o_pick.vec = VEC_W'(idx);
            o_pick.valid = 1'b1;
        end
    end

endmodule

// ===== rtl/core/two_level_interrupt_arbiter.sv =====
// Two-level interrupt arbiter. Each input beat is one event (raise, clear,
// cpu acknowledge, return from interrupt) and yields exactly one result beat
// with the next vector to serve and the two level flags after the event.
// The block takes one beat per clock while the output is not stalled. An
// accepted beat is held in the input register; the result register loads
// from it once the result slot is empty or not stalled, and the result beat
// can be taken while the output is not stalled. The pending mask update and
// the rotating priority search sit together in the single stage between the
// input register and the result register, so that stage sets the clock rate.
// Configuration (index 0 high-level vector, index 1 rotate start) is always
// ready and must only be written while no event is in flight.
`include "two_level_interrupt_arbiter_defines.svh"

module two_level_interrupt_arbiter
    import tlia_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // event channel
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in                  i_in_data,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out                 o_out_data,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic               r_in_valid;
    t_in                r_in;
    logic               r_out_valid;
    t_out               r_out;
    logic [VEC_CNT-1:0] r_pending;
    logic [VEC_CNT-1:0] n_pending;
    t_flags             r_flags;
    t_flags             n_flags;
    logic [VEC_W-1:0]   r_high_vec;
    logic [VEC_W-1:0]   r_rot_start;
    logic               adv;
    logic               in_acc;
    logic [VEC_CNT-1:0] vec_onehot;
    t_pick              pick;

    // handshake
    assign adv = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !adv;
    assign in_acc = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_vec <= '0;
            r_rot_start <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_HIGH_VEC) begin
                r_high_vec <= VEC_W'(i_cfg_data);
            end
            if (i_cfg_index == CFG_ROT_START) begin
                r_rot_start <= VEC_W'(i_cfg_data);
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_acc) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_data;
        end
    end

    // event decode: one-hot of the event vector, which is always in range
    assign vec_onehot = VEC_CNT'(1) << r_in.vector;

    always_comb begin
        n_pending = r_pending;
        n_flags = r_flags;
        unique case (r_in.cmd)
            CMD_RAISE: begin
                n_pending = r_pending | vec_onehot;
            end
            CMD_CLEAR: begin
                n_pending = r_pending & ~vec_onehot;
            end
            CMD_ACK: begin
                n_pending = r_pending | vec_onehot;
                if (r_in.vector != '0) begin
                    if (r_in.vector == r_high_vec) begin
                        n_flags.high = 1'b1;
                    end else begin
                        n_flags.norm = 1'b1;
                    end
                end
            end
            CMD_RET: begin
                if (r_flags.high) begin
                    n_flags.high = 1'b0;
                end else begin
                    n_flags.norm = 1'b0;
                end
            end
            default: begin
                n_pending = r_pending;
                n_flags = r_flags;
            end
        endcase
    end

    // next vector search on the updated state
    tlia_pick u_pick (
        .i_pending   (n_pending),
        .i_flags     (n_flags),
        .i_high_vec  (r_high_vec),
        .i_rot_start (r_rot_start),
        .o_pick      (pick)
    );

    // arbiter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_flags <= '0;
        end else if (adv) begin
            r_pending <= n_pending;
            r_flags <= n_flags;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.next_vector <= pick.vec;
            r_out.next_valid <= pick.valid;
            r_out.normal_active <= n_flags.norm;
            r_out.high_active <= n_flags.high;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data = r_out;

    // checks
    `TLIA_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid && !o_in_stall, "pipeline not empty after reset")
    `TLIA_ASSERT(a_high_blocks, i_clk, i_rst_n, o_out_valid && o_out_data.high_active |-> !o_out_data.next_valid, "vector reported while high level active")
    `TLIA_ASSERT(a_none_zero, i_clk, i_rst_n, o_out_valid && !o_out_data.next_valid |-> o_out_data.next_vector == '0, "nonzero vector without valid")
    `TLIA_ASSERT(a_ret_high, i_clk, i_rst_n, adv && r_in.cmd == CMD_RET && r_flags.high |=> !r_flags.high && $stable(r_flags.norm), "return did not drop the high level alone")

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import tlia_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 6;
    localparam int REPORT_MAX    = 10;
    localparam int PHASE_ITEMS   = 175;
    localparam int PHASE_COUNT   = 8;

    // clock, reset and block ports
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in                   i_in_data   = '0;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out                  o_out_data;
    logic                  o_cfg_ready;

    // predicted arbiter state and register copies
    logic [VEC_CNT-1:0] pend_bits  = '0;
    logic               lvl_norm   = 1'b0;
    logic               lvl_high   = 1'b0;
    logic [VEC_W-1:0]   hv_reg     = '0;
    logic [VEC_W-1:0]   rot_reg    = '0;
    t_out               last_pick  = '0;
    t_out               serve_q[$];

    int mismatches  = 0;
    int cycles      = 0;
    int burst_left  = 0;
    int stall_left  = 0;
    bit stall_on    = 1'b0;
    bit send_calm   = 1'b0;
    bit stall_calm  = 1'b0;

    two_level_interrupt_arbiter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // apply one event to the predicted state and return the vector to serve
    function automatic t_out serve_event(input t_in ev);
        t_out r;
        int   v;
        r = '0;
        case (ev.cmd)
            CMD_RAISE: pend_bits[ev.vector] = 1'b1;
            CMD_CLEAR: pend_bits[ev.vector] = 1'b0;
            CMD_ACK: begin
                if (ev.vector != '0) begin
                    if (ev.vector == hv_reg) lvl_high = 1'b1;
                    else lvl_norm = 1'b1;
                end
                // acked vector is marked pending
                pend_bits[ev.vector] = 1'b1;
            end
            default: begin
                if (lvl_high) lvl_high = 1'b0;
                else lvl_norm = 1'b0;
            end
        endcase
        r.normal_active = lvl_norm;
        r.high_active   = lvl_high;
        // high flag blocks all, high vector beats the normal level
        if (!lvl_high) begin
            if (hv_reg != '0 && pend_bits[hv_reg]) begin
                r.next_vector = hv_reg;
                r.next_valid  = 1'b1;
            end else if (!lvl_norm) begin
                for (int i = 1; i <= VEC_CNT; i++) begin
                    v = (rot_reg == '0) ? i - 1 : (i + rot_reg) % VEC_CNT;
                    if (!r.next_valid && pend_bits[v]) begin
                        r.next_vector = v[VEC_W-1:0];
                        r.next_valid  = 1'b1;
                    end
                end
            end
        end
        return r;
    endfunction

    // send one event beat, idling between bursts
    task automatic send_event(input t_cmd cmd, input logic [VEC_W-1:0] vec);
        int  gap;
        t_in ev;
        ev.cmd    = cmd;
        ev.vector = vec;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 20);
            gap = send_calm ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= ev;
        do @(posedge i_clk); while (o_in_stall);
        last_pick = serve_event(ev);
        serve_q.push_back(last_pick);
    endtask

    // stop sending and wait until every expected result has come back
    task automatic wait_results_drained();
        i_in_valid <= 1'b0;
        while (serve_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write both registers; valid stays high across the two beats
    task automatic write_config(input logic [VEC_W-1:0] hv, input logic [VEC_W-1:0] rot);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_HIGH_VEC;
        i_cfg_data  <= hv;
        do @(posedge i_clk); while (!o_cfg_ready);
        hv_reg = hv;
        i_cfg_index <= CFG_ROT_START;
        i_cfg_data  <= rot;
        do @(posedge i_clk); while (!o_cfg_ready);
        rot_reg = rot;
        i_cfg_valid <= 1'b0;
    endtask

    // receiver stall pattern: segments of stalling and of flowing
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_left = $urandom_range(1, 12);
            stall_on   = !stall_calm && ($urandom_range(0, 2) == 0);
        end
        stall_left--;
        i_out_stall <= stall_on && ($urandom_range(0, 3) != 0);
    end

    // compare each result beat with the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_out want;
        t_out got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = o_out_data;
            if (serve_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result beat: vec=%0d valid=%0b norm=%0b high=%0b",
                             got.next_vector, got.next_valid,
                             got.normal_active, got.high_active);
            end else begin
                want = serve_q.pop_front();
                if (got.next_vector !== want.next_vector ||
                    got.next_valid !== want.next_valid ||
                    got.normal_active !== want.normal_active ||
                    got.high_active !== want.high_active) begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display({"result mismatch: exp vec=%0d valid=%0b norm=%0b high=%0b",
                                  " / act vec=%0d valid=%0b norm=%0b high=%0b"},
                                 want.next_vector, want.next_valid,
                                 want.normal_active, want.high_active,
                                 got.next_vector, got.next_valid,
                                 got.normal_active, got.high_active);
                end
            end
        end
    end

    // fixed order search with reset registers, both ends of the vector range
    task automatic test_fixed_order_raise_clear();
        send_event(CMD_RAISE, 5'd31);
        send_event(CMD_RAISE, 5'd0);
        send_event(CMD_CLEAR, 5'd0);
        send_event(CMD_CLEAR, 5'd31);
    endtask

    // ack of vector 0, return with no flag, normal ack and return
    task automatic test_ack_and_return();
        send_event(CMD_ACK, 5'd0);
        send_event(CMD_RET, 5'd31);
        send_event(CMD_RAISE, 5'd7);
        send_event(CMD_ACK, 5'd7);
        send_event(CMD_RET, 5'd0);
        send_event(CMD_CLEAR, 5'd0);
        send_event(CMD_CLEAR, 5'd7);
    endtask

    // high vector wins over an active normal level, high flag blocks all
    task automatic test_high_vector();
        wait_results_drained();
        write_config(5'd31, 5'd0);
        send_event(CMD_RAISE, 5'd31);
        send_event(CMD_RAISE, 5'd3);
        send_event(CMD_ACK, 5'd3);
        send_event(CMD_ACK, 5'd31);
        send_event(CMD_RET, 5'd0);
        send_event(CMD_RET, 5'd0);
        send_event(CMD_CLEAR, 5'd31);
        send_event(CMD_CLEAR, 5'd3);
    endtask

    // rotating search, including the wrap from the last vector
    task automatic test_rotating_search();
        wait_results_drained();
        write_config(5'd0, 5'd31);
        send_event(CMD_RAISE, 5'd31);
        send_event(CMD_RAISE, 5'd0);
        send_event(CMD_CLEAR, 5'd0);
        wait_results_drained();
        write_config(5'd1, 5'd1);
        send_event(CMD_RAISE, 5'd2);
        send_event(CMD_CLEAR, 5'd31);
        send_event(CMD_CLEAR, 5'd2);
    endtask

    // random traffic over several register settings, acks mostly of the offered vector
    task automatic test_random_traffic();
        int               r;
        t_cmd             cmd;
        logic [VEC_W-1:0] vec;
        logic [VEC_W-1:0] hv;
        logic [VEC_W-1:0] rot;
        for (int p = 0; p < PHASE_COUNT; p++) begin
            wait_results_drained();
            case (p)
                0: begin hv = 5'd0;  rot = 5'd0;  end
                1: begin hv = 5'd31; rot = 5'd31; end
                2: begin hv = 5'd0;  rot = 5'd31; end
                3: begin hv = 5'd31; rot = 5'd0;  end
                default: begin
                    hv  = VEC_W'($urandom_range(0, VEC_CNT - 1));
                    rot = VEC_W'($urandom_range(0, VEC_CNT - 1));
                end
            endcase
            write_config(hv, rot);
            send_calm  = (p % 3 == 1);
            stall_calm = (p % 4 == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r = $urandom_range(0, 99);
                if ($urandom_range(0, 99) < 40) vec = VEC_W'($urandom_range(0, 7));
                else if ($urandom_range(0, 99) < 25) vec = hv_reg;
                else vec = VEC_W'($urandom_range(0, VEC_CNT - 1));
                if (r < 35) begin
                    cmd = CMD_RAISE;
                end else if (r < 50) begin
                    cmd = CMD_CLEAR;
                end else if (r < 75) begin
                    cmd = CMD_ACK;
                    // mostly acknowledge what the arbiter offers
                    if (last_pick.next_valid && $urandom_range(0, 4) != 0)
                        vec = last_pick.next_vector;
                end else begin
                    cmd = CMD_RET;
                end
                send_event(cmd, vec);
            end
        end
        send_calm  = 1'b0;
        stall_calm = 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_fixed_order_raise_clear();
        test_ack_and_return();
        test_high_vector();
        test_rotating_search();
        test_random_traffic();
        wait_results_drained();
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/tlia_pkg.sv
rtl/core/tlia_pick.sv
rtl/core/two_level_interrupt_arbiter.sv
tb/sv/tb_top.sv
